@@ design/kdl_pkg.sv @@
package kdl_pkg;

    localparam int CODE_LENGTH = 4;
    localparam int IDX_W       = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
    localparam int KEY_W       = 4;
    localparam int TICK_W      = 24;
    localparam int CFG_IDX_W   = 2;

    localparam logic [KEY_W-1:0] KEY_HASH = 4'd11;

    localparam logic [TICK_W-1:0] PRE_OPEN_RST   = 24'd400000;
    localparam logic [TICK_W-1:0] MOTOR_RUN_RST  = 24'd300000;
    localparam logic [TICK_W-1:0] OPEN_HOLD_RST  = 24'd855000;
    localparam logic [TICK_W-1:0] CLOSE_HOLD_RST = 24'd9500000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRE_OPEN   = 2'd0,
        REG_MOTOR_RUN  = 2'd1,
        REG_OPEN_HOLD  = 2'd2,
        REG_CLOSE_HOLD = 2'd3
    } cfg_reg_t;

    typedef enum logic [7:0] {
        PH_AWAIT_HASH = 8'b0000_0001,
        PH_SET_CODE   = 8'b0000_0010,
        PH_ENTRY      = 8'b0000_0100,
        PH_PRE_OPEN   = 8'b0000_1000,
        PH_OPENING    = 8'b0001_0000,
        PH_HOLD       = 8'b0010_0000,
        PH_CLOSING    = 8'b0100_0000,
        PH_LOCKOUT    = 8'b1000_0000
    } phase_t;

    typedef enum logic [2:0] {
        MSG_NONE      = 3'd0,
        MSG_WRONG_KEY = 3'd1,
        MSG_NEW_CODE  = 3'd2,
        MSG_ENTER     = 3'd3,
        MSG_WRONG_CDE = 3'd4,
        MSG_OPENING   = 3'd5,
        MSG_CLOSING   = 3'd6
    } msg_t;

    typedef enum logic [1:0] {
        MOTOR_OFF     = 2'd0,
        MOTOR_FORWARD = 2'd1,
        MOTOR_REVERSE = 2'd2
    } motor_t;

    typedef enum logic [2:0] {
        PC_AWAIT_HASH = 3'd0,
        PC_SET_CODE   = 3'd1,
        PC_ENTRY      = 3'd2,
        PC_PRE_OPEN   = 3'd3,
        PC_OPENING    = 3'd4,
        PC_HOLD       = 3'd5,
        PC_CLOSING    = 3'd6,
        PC_LOCKOUT    = 3'd7
    } phase_code_t;

    typedef struct packed {
        logic             func;
        logic [KEY_W-1:0] key_code;
    } in_item_t;

    typedef struct packed {
        logic [1:0] motor_drive;
        logic       echo_star;
        logic [2:0] message;
        logic [2:0] lock_phase;
    } out_item_t;

    typedef struct packed {
        logic [TICK_W-1:0] pre_open_ticks;
        logic [TICK_W-1:0] motor_run_ticks;
        logic [TICK_W-1:0] open_hold_ticks;
        logic [TICK_W-1:0] close_hold_ticks;
    } timing_cfg_t;

    function automatic logic [TICK_W-1:0] duration_of(phase_t ph, timing_cfg_t cfg);
        logic [TICK_W-1:0] d;
        case (ph)
            PH_PRE_OPEN: d = cfg.pre_open_ticks;
            PH_OPENING:  d = cfg.motor_run_ticks;
            PH_HOLD:     d = cfg.open_hold_ticks;
            PH_CLOSING:  d = cfg.motor_run_ticks;
            PH_LOCKOUT:  d = cfg.close_hold_ticks;
            default:     d = '0;
        endcase
        return d;
    endfunction

    function automatic phase_code_t phase_code(phase_t ph);
        phase_code_t c;
        case (ph)
            PH_AWAIT_HASH: c = PC_AWAIT_HASH;
            PH_SET_CODE:   c = PC_SET_CODE;
            PH_ENTRY:      c = PC_ENTRY;
            PH_PRE_OPEN:   c = PC_PRE_OPEN;
            PH_OPENING:    c = PC_OPENING;
            PH_HOLD:       c = PC_HOLD;
            PH_CLOSING:    c = PC_CLOSING;
            PH_LOCKOUT:    c = PC_LOCKOUT;
            default:       c = PC_AWAIT_HASH;
        endcase
        return c;
    endfunction

endpackage

@@ design/keypad_door_lock_controller.sv @@
// Keypad door lock. Each transaction on s_ is a key press (func 0) or a timer tick
// (func 1) and gives exactly one transaction on m_ with motor drive, star echo,
// message and the phase after the step. Each goes through an input register,
// then a result register; one transaction is taken every cycle, and s_ready only
// drops while both registers hold data and m_ready is low. The whole lock FSM
// update sits between those two registers. Door timings are tick counts set
// through cfg_wr_en/cfg_index/cfg_wdata and take effect at the next phase load;
// write them only while the lock is quiet.
module keypad_door_lock_controller (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  kdl_pkg::in_item_t               s_item,
    output logic                            m_valid,
    input  logic                            m_ready,
    output kdl_pkg::out_item_t              m_item,
    input  logic                            cfg_wr_en,
    input  logic [kdl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kdl_pkg::TICK_W-1:0]      cfg_wdata
);

    logic                  in_valid_reg, in_valid_next;
    kdl_pkg::in_item_t     in_item_reg;
    logic                  out_valid_reg, out_valid_next;
    kdl_pkg::out_item_t    out_item_reg;
    logic                  advance;
    kdl_pkg::timing_cfg_t  timing_cfg;
    kdl_pkg::out_item_t    step_result;

    kdl_cfg_regs u_cfg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .timing_cfg (timing_cfg)
    );

    kdl_step u_step (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step_en    (advance),
        .item       (in_item_reg),
        .timing_cfg (timing_cfg),
        .result     (step_result)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = s_ready ? s_valid : in_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) in_item_reg  <= s_item;
        if (advance)            out_item_reg <= step_result;
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule

@@ design/kdl_cfg_regs.sv @@
module kdl_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [kdl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [kdl_pkg::TICK_W-1:0]      cfg_wdata,
    output kdl_pkg::timing_cfg_t            timing_cfg
);

    kdl_pkg::timing_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pre_open_ticks   <= kdl_pkg::PRE_OPEN_RST;
            cfg_reg.motor_run_ticks  <= kdl_pkg::MOTOR_RUN_RST;
            cfg_reg.open_hold_ticks  <= kdl_pkg::OPEN_HOLD_RST;
            cfg_reg.close_hold_ticks <= kdl_pkg::CLOSE_HOLD_RST;
        end else if (cfg_wr_en) begin
            case (kdl_pkg::cfg_reg_t'(cfg_index))
                kdl_pkg::REG_PRE_OPEN:   cfg_reg.pre_open_ticks   <= cfg_wdata;
                kdl_pkg::REG_MOTOR_RUN:  cfg_reg.motor_run_ticks  <= cfg_wdata;
                kdl_pkg::REG_OPEN_HOLD:  cfg_reg.open_hold_ticks  <= cfg_wdata;
                kdl_pkg::REG_CLOSE_HOLD: cfg_reg.close_hold_ticks <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign timing_cfg = cfg_reg;

endmodule

@@ design/kdl_step.sv @@
module kdl_step (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step_en,
    input  kdl_pkg::in_item_t     item,
    input  kdl_pkg::timing_cfg_t  timing_cfg,
    output kdl_pkg::out_item_t    result
);

    kdl_pkg::phase_t                  phase_reg, phase_next;
    logic [kdl_pkg::IDX_W-1:0]        digit_reg, digit_next;
    logic [kdl_pkg::TICK_W-1:0]       timer_reg, timer_next;
    logic [kdl_pkg::KEY_W-1:0]        stored_reg  [kdl_pkg::CODE_LENGTH];
    logic [kdl_pkg::KEY_W-1:0]        entered_reg [kdl_pkg::CODE_LENGTH];

    logic                             wr_stored;
    logic                             wr_entered;
    logic                             last_digit;
    logic                             code_match;
    logic                             echo;
    kdl_pkg::msg_t                    msg;
    kdl_pkg::motor_t                  motor;

    assign last_digit = (digit_reg == kdl_pkg::IDX_W'(kdl_pkg::CODE_LENGTH - 1));

    // last key of the entry is compared before it lands in the register
    always_comb begin
        code_match = 1'b1;
        for (int i = 0; i < kdl_pkg::CODE_LENGTH; i++) begin
            if (digit_reg == kdl_pkg::IDX_W'(i)) begin
                if (stored_reg[i] != item.key_code) code_match = 1'b0;
            end else if (stored_reg[i] != entered_reg[i]) begin
                code_match = 1'b0;
            end
        end
    end

    always_comb begin
        phase_next = phase_reg;
        digit_next = digit_reg;
        timer_next = timer_reg;
        wr_stored  = 1'b0;
        wr_entered = 1'b0;
        echo       = 1'b0;
        msg        = kdl_pkg::MSG_NONE;

        if (phase_reg inside {kdl_pkg::PH_PRE_OPEN, kdl_pkg::PH_OPENING, kdl_pkg::PH_HOLD,
                              kdl_pkg::PH_CLOSING, kdl_pkg::PH_LOCKOUT}) begin
            if (item.func) begin
                if (timer_reg > kdl_pkg::TICK_W'(1)) begin
                    timer_next = timer_reg - kdl_pkg::TICK_W'(1);
                end else begin
                    case (phase_reg)
                        kdl_pkg::PH_PRE_OPEN: phase_next = kdl_pkg::PH_OPENING;
                        kdl_pkg::PH_OPENING:  phase_next = kdl_pkg::PH_HOLD;
                        kdl_pkg::PH_HOLD: begin
                            phase_next = kdl_pkg::PH_CLOSING;
                            msg        = kdl_pkg::MSG_CLOSING;
                        end
                        kdl_pkg::PH_CLOSING:  phase_next = kdl_pkg::PH_LOCKOUT;
                        default: begin
                            phase_next = kdl_pkg::PH_ENTRY;
                            msg        = kdl_pkg::MSG_ENTER;
                        end
                    endcase
                    timer_next = kdl_pkg::duration_of(phase_next, timing_cfg);
                    if (phase_next == kdl_pkg::PH_ENTRY) digit_next = '0;
                end
            end
        end else if (!item.func) begin
            case (phase_reg)
                kdl_pkg::PH_AWAIT_HASH: begin
                    if (item.key_code == kdl_pkg::KEY_HASH) begin
                        phase_next = kdl_pkg::PH_SET_CODE;
                        digit_next = '0;
                        msg        = kdl_pkg::MSG_NEW_CODE;
                    end else begin
                        msg = kdl_pkg::MSG_WRONG_KEY;
                    end
                end
                default: begin
                    echo       = 1'b1;
                    wr_stored  = (phase_reg == kdl_pkg::PH_SET_CODE);
                    wr_entered = (phase_reg != kdl_pkg::PH_SET_CODE);
                    digit_next = digit_reg + kdl_pkg::IDX_W'(1);
                    if (last_digit) begin
                        digit_next = '0;
                        if (phase_reg == kdl_pkg::PH_SET_CODE) begin
                            phase_next = kdl_pkg::PH_ENTRY;
                            msg        = kdl_pkg::MSG_ENTER;
                        end else if (code_match) begin
                            phase_next = kdl_pkg::PH_PRE_OPEN;
                            timer_next = kdl_pkg::duration_of(kdl_pkg::PH_PRE_OPEN,
                                                              timing_cfg);
                            msg        = kdl_pkg::MSG_OPENING;
                        end else begin
                            msg = kdl_pkg::MSG_WRONG_CDE;
                        end
                    end
                end
            endcase
        end

        case (phase_next)
            kdl_pkg::PH_OPENING: motor = kdl_pkg::MOTOR_FORWARD;
            kdl_pkg::PH_CLOSING: motor = kdl_pkg::MOTOR_REVERSE;
            default:             motor = kdl_pkg::MOTOR_OFF;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= kdl_pkg::PH_AWAIT_HASH;
            digit_reg <= '0;
            timer_reg <= '0;
        end else if (step_en) begin
            phase_reg <= phase_next;
            digit_reg <= digit_next;
            timer_reg <= timer_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en && wr_stored)  stored_reg[digit_reg]  <= item.key_code;
        if (step_en && wr_entered) entered_reg[digit_reg] <= item.key_code;
    end

    assign result.motor_drive = motor;
    assign result.echo_star   = echo;
    assign result.message     = msg;
    assign result.lock_phase  = kdl_pkg::phase_code(phase_next);

endmodule

@@ design/kdl_checker.sv @@
module kdl_checker (
    input logic                aclk,
    input logic                aresetn,
    input kdl_pkg::out_item_t  m_item,
    input logic                m_valid,
    input logic                m_ready
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid straight after reset");

    // motor follows the door phase
    a_motor_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_item.motor_drive == kdl_pkg::MOTOR_FORWARD) ==
                     (m_item.lock_phase == kdl_pkg::PC_OPENING)) &&
                    ((m_item.motor_drive == kdl_pkg::MOTOR_REVERSE) ==
                     (m_item.lock_phase == kdl_pkg::PC_CLOSING)))
        else $error("motor drive does not match phase");

    a_echo_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.echo_star |-> m_item.lock_phase == kdl_pkg::PC_SET_CODE ||
                                        m_item.lock_phase == kdl_pkg::PC_ENTRY ||
                                        m_item.lock_phase == kdl_pkg::PC_PRE_OPEN)
        else $error("star echoed outside code entry");

    a_open_msg: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.message == kdl_pkg::MSG_OPENING |->
            m_item.lock_phase == kdl_pkg::PC_PRE_OPEN && m_item.echo_star)
        else $error("opening message without accepted code");

endmodule

bind keypad_door_lock_controller kdl_checker u_kdl_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_item  (m_item),
    .m_valid (m_valid),
    .m_ready (m_ready)
);

@@ verif/lock_result_checker.sv @@
`timescale 1ns / 1ps

module lock_result_checker
    import kdl_pkg::*;
(
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    input  logic                                  s_ready,
    input  in_item_t                              s_item,
    input  logic                                  m_valid,
    input  logic                                  m_ready,
    input  out_item_t                             m_item,
    input  logic                                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]                  cfg_index,
    input  logic [TICK_W-1:0]                     cfg_wdata,
    output int                                    fail_count,
    output int                                    results_owed,
    output int                                    results_seen,
    output int                                    doors_opened,
    output phase_code_t                           lock_phase,
    output int                                    key_count,
    output logic [CODE_LENGTH-1:0][KEY_W-1:0]     code_set
);

    logic [CODE_LENGTH-1:0][KEY_W-1:0] code_tried;
    logic [TICK_W-1:0]                 phase_timer;
    timing_cfg_t                       timing;
    out_item_t                         pending_results [$];

    function automatic logic [TICK_W-1:0] load_for(phase_code_t ph);
        logic [TICK_W-1:0] d;
        case (ph)
            PC_PRE_OPEN:             d = timing.pre_open_ticks;
            PC_OPENING, PC_CLOSING:  d = timing.motor_run_ticks;
            PC_HOLD:                 d = timing.open_hold_ticks;
            PC_LOCKOUT:              d = timing.close_hold_ticks;
            default:                 d = '0;
        endcase
        return d;
    endfunction

    // Moves the lock on by one transaction and returns what the block should report.
    function automatic out_item_t advance_lock(in_item_t it);
        out_item_t r;
        logic      echo;
        msg_t      msg;
        motor_t    motor;
        echo = 1'b0;
        msg  = MSG_NONE;
        if (lock_phase >= PC_PRE_OPEN) begin
            // door sequence: only ticks count, a zero timer moves on at once
            if (it.func) begin
                if (phase_timer != '0) phase_timer = phase_timer - 1'b1;
                if (phase_timer == '0) begin
                    if (lock_phase == PC_LOCKOUT) begin
                        lock_phase = PC_ENTRY;
                        key_count  = 0;
                        msg        = MSG_ENTER;
                    end else begin
                        lock_phase  = phase_code_t'(lock_phase + 1);
                        phase_timer = load_for(lock_phase);
                        if (lock_phase == PC_CLOSING) msg = MSG_CLOSING;
                    end
                end
            end
        end else if (!it.func) begin
            if (lock_phase == PC_AWAIT_HASH) begin
                if (it.key_code == KEY_HASH) begin
                    lock_phase = PC_SET_CODE;
                    key_count  = 0;
                    msg        = MSG_NEW_CODE;
                end else begin
                    msg = MSG_WRONG_KEY;
                end
            end else begin
                if (lock_phase == PC_SET_CODE) code_set[key_count] = it.key_code;
                else code_tried[key_count] = it.key_code;
                echo = 1'b1;
                if (key_count == CODE_LENGTH - 1) begin
                    key_count = 0;
                    if (lock_phase == PC_SET_CODE) begin
                        lock_phase = PC_ENTRY;
                        msg        = MSG_ENTER;
                    end else if (code_tried == code_set) begin
                        lock_phase  = PC_PRE_OPEN;
                        phase_timer = load_for(PC_PRE_OPEN);
                        msg         = MSG_OPENING;
                        doors_opened++;
                    end else begin
                        msg = MSG_WRONG_CDE;
                    end
                end else begin
                    key_count++;
                end
            end
        end
        case (lock_phase)
            PC_OPENING: motor = MOTOR_FORWARD;
            PC_CLOSING: motor = MOTOR_REVERSE;
            default:    motor = MOTOR_OFF;
        endcase
        r.motor_drive = motor;
        r.echo_star   = echo;
        r.message     = msg;
        r.lock_phase  = lock_phase;
        return r;
    endfunction

    function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endfunction

    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            lock_phase   = PC_AWAIT_HASH;
            key_count    = 0;
            code_set     = '0;
            code_tried   = '0;
            phase_timer  = '0;
            timing.pre_open_ticks   = PRE_OPEN_RST;
            timing.motor_run_ticks  = MOTOR_RUN_RST;
            timing.open_hold_ticks  = OPEN_HOLD_RST;
            timing.close_hold_ticks = CLOSE_HOLD_RST;
            pending_results.delete();
            fail_count   = 0;
            results_seen = 0;
            doors_opened = 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_index))
                    REG_PRE_OPEN:   timing.pre_open_ticks   = cfg_wdata;
                    REG_MOTOR_RUN:  timing.motor_run_ticks  = cfg_wdata;
                    REG_OPEN_HOLD:  timing.open_hold_ticks  = cfg_wdata;
                    REG_CLOSE_HOLD: timing.close_hold_ticks = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) pending_results.push_back(advance_lock(s_item));
            if (m_valid && m_ready) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected transaction on result channel, expected none, got %h",
                             $time, m_item);
                end else begin
                    want = pending_results.pop_front();
                    check_field("motor_drive", 8'(want.motor_drive), 8'(m_item.motor_drive));
                    check_field("echo_star",   8'(want.echo_star),   8'(m_item.echo_star));
                    check_field("message",     8'(want.message),     8'(m_item.message));
                    check_field("lock_phase",  8'(want.lock_phase),  8'(m_item.lock_phase));
                end
            end
        end
        results_owed = pending_results.size();
    end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import kdl_pkg::*;

    localparam logic             FUNC_KEY        = 1'b0;
    localparam logic             FUNC_TICK       = 1'b1;
    localparam logic [KEY_W-1:0] KEY_STAR        = 4'd10;
    localparam logic [TICK_W-1:0] TICKS_MAX      = '1;
    localparam int               CYCLE_LIMIT     = 250000;
    localparam int               HOLD_OFF_CYCLES = 300;
    localparam int               DRAIN_CYCLES    = 20;
    localparam int               SIDE_SEND       = 0;
    localparam int               SIDE_RECV       = 1;
    localparam int               N_DIRECTED      = 26;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    in_item_t             s_item;
    logic                 m_valid;
    logic                 m_ready;
    out_item_t            m_item;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [TICK_W-1:0]    cfg_wdata;

    int                   fail_count;
    int                   results_owed;
    int                   results_seen;
    int                   doors_opened;
    phase_code_t          lock_phase;
    int                   key_count;
    logic [CODE_LENGTH-1:0][KEY_W-1:0] code_set;

    int                   cycle_count = 0;
    int                   items_sent = 0;
    int                   hold_off_reqs = 0;
    int                   hold_offs_done = 0;
    int                   stretch_left [2] = '{0, 0};
    bit                   stretch_idles [2];
    logic [KEY_W:0]       directed_seq [N_DIRECTED];

    keypad_door_lock_controller uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    lock_result_checker checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_item       (s_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_item       (m_item),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .results_owed (results_owed),
        .results_seen (results_seen),
        .doors_opened (doors_opened),
        .lock_phase   (lock_phase),
        .key_count    (key_count),
        .code_set     (code_set)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // Each stretch is at random either idle or a burst that never waits.
    function automatic int draw_wait(int side);
        if (stretch_left[side] == 0) begin
            stretch_left[side]  = $urandom_range(60, 10);
            stretch_idles[side] = ($urandom_range(2) != 0);
        end
        stretch_left[side]--;
        return stretch_idles[side] ? $urandom_range(14) : 0;
    endfunction

    function automatic in_item_t mk_item(logic f, logic [KEY_W-1:0] k);
        in_item_t it;
        it.func     = f;
        it.key_code = k;
        return it;
    endfunction

    // Mostly well-formed: hash to start, right keys at entry, ticks through the door run.
    function automatic in_item_t pick_item();
        int               roll;
        logic [KEY_W-1:0] k;
        in_item_t         it;
        roll = $urandom_range(99);
        k    = KEY_W'($urandom_range(15));
        case (lock_phase)
            PC_AWAIT_HASH: begin
                if (roll < 70) it = mk_item(FUNC_KEY, KEY_HASH);
                else if (roll < 80) it = mk_item(FUNC_TICK, k);
                else it = mk_item(FUNC_KEY, k);
            end
            PC_SET_CODE, PC_ENTRY: begin
                if (roll < 8) it = mk_item(FUNC_TICK, k);
                else if (lock_phase == PC_ENTRY && roll < 92)
                    it = mk_item(FUNC_KEY, code_set[key_count]);
                else it = mk_item(FUNC_KEY, k);
            end
            default: begin
                if (roll < 85) it = mk_item(FUNC_TICK, k);
                else it = mk_item(FUNC_KEY, k);
            end
        endcase
        return it;
    endfunction

    task automatic send_item(input in_item_t it);
        int gap;
        gap = draw_wait(SIDE_SEND);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic write_timings(input logic [TICK_W-1:0] pre, run, hold, lockout);
        logic [TICK_W-1:0] vals [4];
        cfg_reg_t          regs [4];
        vals = '{pre, run, hold, lockout};
        regs = '{REG_PRE_OPEN, REG_MOTOR_RUN, REG_OPEN_HOLD, REG_CLOSE_HOLD};
        while (results_owed != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= regs[i];
            cfg_wdata <= vals[i];
            @(negedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(input int count, input int hold_off_at);
        for (int n = 0; n < count; n++) begin
            if (n == hold_off_at) hold_off_reqs++;
            send_item(pick_item());
        end
        s_valid <= 1'b0;
    endtask

    // result side: random stalls, plus long hold-offs on request
    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (hold_off_reqs != hold_offs_done) begin
                hold_offs_done++;
                m_ready <= 1'b0;
                for (int c = 0; c < HOLD_OFF_CYCLES; c++) @(negedge aclk);
            end
            stall = draw_wait(SIDE_RECV);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_item    = '0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_PRE_OPEN;
        cfg_wdata = '0;
        // wrong keys, set code 0 15 * #, one bad try, the right code, then the door run
        directed_seq = '{
            {FUNC_KEY, 4'd5},      {FUNC_KEY, 4'd15},     {FUNC_TICK, 4'd0},
            {FUNC_KEY, KEY_HASH},  {FUNC_KEY, 4'd0},      {FUNC_KEY, 4'd15},
            {FUNC_TICK, 4'd15},    {FUNC_KEY, KEY_STAR},  {FUNC_KEY, KEY_HASH},
            {FUNC_KEY, 4'd0},      {FUNC_KEY, 4'd0},      {FUNC_KEY, 4'd0},
            {FUNC_KEY, 4'd0},      {FUNC_KEY, 4'd0},      {FUNC_KEY, 4'd15},
            {FUNC_KEY, KEY_STAR},  {FUNC_KEY, KEY_HASH},  {FUNC_TICK, 4'd0},
            {FUNC_KEY, 4'd7},      {FUNC_TICK, 4'd0},     {FUNC_TICK, 4'd0},
            {FUNC_TICK, 4'd0},     {FUNC_TICK, 4'd0},     {FUNC_TICK, 4'd0},
            {FUNC_TICK, 4'd0},     {FUNC_TICK, 4'd0}
        };
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        write_timings(24'd0, 24'd1, 24'd2, 24'd3);
        for (int i = 0; i < N_DIRECTED; i++) send_item(in_item_t'(directed_seq[i]));
        s_valid <= 1'b0;

        write_timings('0, '0, '0, '0);
        run_phase(200, -1);
        write_timings(TICK_W'($urandom_range(4)), TICK_W'($urandom_range(4)),
                      TICK_W'($urandom_range(4)), TICK_W'($urandom_range(4)));
        run_phase(180, -1);
        // receiver stalls long enough to back the block up
        write_timings(TICK_W'($urandom_range(3)), TICK_W'($urandom_range(3)),
                      TICK_W'($urandom_range(3)), TICK_W'($urandom_range(3)));
        run_phase(200, 60);
        write_timings(24'd1, TICK_W'($urandom_range(12)), TICK_W'($urandom_range(12)),
                      TICK_W'($urandom_range(12)));
        run_phase(180, -1);
        write_timings(TICK_W'($urandom_range(2)), TICK_W'($urandom_range(8)),
                      TICK_W'($urandom_range(2)), TICK_W'($urandom_range(8)));
        run_phase(160, -1);
        write_timings(TICKS_MAX, TICKS_MAX, TICKS_MAX, TICKS_MAX);
        run_phase(120, -1);

        while (results_owed != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        $display("Sent %0d transactions over %0d cycles, %0d results checked, %0d doors opened;",
                 items_sent, cycle_count, results_seen, doors_opened);
        $display("timings ran from all zero through small random values to all ones, with stalls.");
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
